FILE: rtl/fat32_boot_record_validate_defines.svh
// assertion macros for the fat32 boot record checker
`ifndef FAT32_BOOT_RECORD_VALIDATE_DEFINES_SVH
`define FAT32_BOOT_RECORD_VALIDATE_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define FBRV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked during reset too
`define FBRV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBRV_ASSERT(label, prop, msg)
`define FBRV_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: rtl/fbrv_pkg.sv
package fbrv_pkg;

    localparam int unsigned W_LBA = 32;

    localparam logic [15:0] BPS_512  = 16'd512;
    localparam logic [15:0] BPS_1024 = 16'd1024;
    localparam logic [15:0] BPS_2048 = 16'd2048;
    localparam logic [15:0] BPS_4096 = 16'd4096;

    localparam logic [15:0] DEV_BYTES_RESET = BPS_512;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NOT_FS = 1'b1;

    typedef struct packed {
        logic [15:0]      root_entry_count;
        logic [15:0]      total_sectors_small;
        logic [15:0]      fat_size_small;
        logic [15:0]      bytes_per_sector;
        logic [7:0]       sectors_per_cluster;
        logic [15:0]      reserved_sectors;
        logic [7:0]       fat_copies;
        logic [W_LBA-1:0] fat_size_sectors;
        logic [W_LBA-1:0] total_sectors;
        logic [W_LBA-1:0] root_cluster_in;
        logic [W_LBA-1:0] partition_start_lba;
        logic [W_LBA-1:0] partition_size;
    } t_fbrv_in;

    typedef struct packed {
        logic             status;
        logic [W_LBA-1:0] fat_start_lba;
        logic [W_LBA-1:0] data_start_lba;
        logic [W_LBA-1:0] highest_cluster;
    } t_fbrv_out;

endpackage

FILE: rtl/fat32_boot_record_validate.sv
// fat32 boot record geometry check, five register stages deep
// a beat passes the stage 1 to 4 registers, then the output register, to o_out
// throughput: one beat per cycle; each stage moves on when the next one is empty or moving
// stalls: o_in_stall rises only when every stage holds a beat and the output is stalled
// reset: synchronous active low; empties the pipeline and sets device block size to 512
`include "fat32_boot_record_validate_defines.svh"

module fat32_boot_record_validate
    import fbrv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration write channel
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input beat channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_fbrv_in  i_in,
    // result beat channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_fbrv_out o_out
);

    // device block size register, always writable
    logic [15:0] r_dev_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_bytes <= DEV_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dev_bytes <= i_cfg_data;
        end
    end

    // per stage advance: a stage loads when it is empty or its beat moves on
    logic r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r_out_valid || !i_out_stall;
    assign rdy4 = !r4_valid || rdy5;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_in_valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
            if (rdy5) begin
                r_out_valid <= r4_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: field checks, fat area product, partition sums
    // ------------------------------------------------------------------
    logic        n1_ok;
    logic        s1_bps_ok;
    logic        s1_spc_ok;
    logic [39:0] n1_fatsec;
    logic [32:0] n1_flba;
    logic [32:0] n1_end;

    logic        r1_ok;
    logic [39:0] r1_fatsec;
    logic [32:0] r1_flba;
    logic [32:0] r1_end;
    logic [15:0] r1_rsv;
    logic [31:0] r1_fatsz;
    logic [31:0] r1_tot;
    logic [31:0] r1_root;
    logic [7:0]  r1_spc;
    logic [2:0]  r1_sh;
    logic [13:0] r1_epb;
    logic [2:0]  n1_sh;

    always_comb begin
        case (i_in.bytes_per_sector)
            BPS_512, BPS_1024, BPS_2048, BPS_4096: s1_bps_ok = 1'b1;
            default:                               s1_bps_ok = 1'b0;
        endcase
    end

    // cluster size must be a single set bit; its position is the divide shift
    assign s1_spc_ok = (i_in.sectors_per_cluster != 8'd0)
                    && ((i_in.sectors_per_cluster & (i_in.sectors_per_cluster - 8'd1)) == 8'd0);

    always_comb begin
        n1_sh = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (i_in.sectors_per_cluster[b]) begin
                n1_sh = 3'(b);
            end
        end
    end

    assign n1_ok = (i_in.root_entry_count == 16'd0)
                && (i_in.total_sectors_small == 16'd0)
                && (i_in.fat_size_small == 16'd0)
                && s1_bps_ok
                && (i_in.bytes_per_sector == r_dev_bytes)
                && s1_spc_ok
                && (i_in.reserved_sectors != 16'd0)
                && (i_in.fat_copies != 8'd0)
                && (i_in.fat_size_sectors != 32'd0)
                && (i_in.total_sectors != 32'd0)
                && (i_in.root_cluster_in >= 32'd2)
                // a partition size of zero is unknown and skips the bound
                && !((i_in.partition_size != 32'd0)
                     && (i_in.total_sectors > i_in.partition_size));

    assign n1_fatsec = {32'd0, i_in.fat_copies} * {8'd0, i_in.fat_size_sectors};
    assign n1_flba   = {1'b0, i_in.partition_start_lba} + {17'd0, i_in.reserved_sectors};
    assign n1_end    = {1'b0, i_in.partition_start_lba} + {1'b0, i_in.total_sectors};

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_ok     <= n1_ok;
            r1_fatsec <= n1_fatsec;
            r1_flba   <= n1_flba;
            r1_end    <= n1_end;
            r1_rsv    <= i_in.reserved_sectors;
            r1_fatsz  <= i_in.fat_size_sectors;
            r1_tot    <= i_in.total_sectors;
            r1_root   <= i_in.root_cluster_in;
            r1_spc    <= i_in.sectors_per_cluster;
            r1_sh     <= n1_sh;
            // fat entries per sector (4 bytes each)
            r1_epb    <= r_dev_bytes[15:2];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: non-data size, data start, fat entry limit
    // ------------------------------------------------------------------
    logic [40:0] n2_nondata;
    logic [40:0] n2_dlba;
    logic [45:0] n2_maxfat;
    logic        n2_ok;

    logic        r2_ok;
    logic [31:0] r2_nondata;
    logic [31:0] r2_dlba;
    logic [31:0] r2_flba;
    logic [31:0] r2_end;
    logic [31:0] r2_tot;
    logic [31:0] r2_root;
    logic [31:0] r2_maxfat;
    logic [7:0]  r2_spc;
    logic [2:0]  r2_sh;

    assign n2_nondata = {1'b0, r1_fatsec} + {25'd0, r1_rsv};
    assign n2_dlba    = {1'b0, r1_fatsec} + {8'd0, r1_flba};
    assign n2_maxfat  = {14'd0, r1_fatsz} * {32'd0, r1_epb};

    assign n2_ok = r1_ok
                && (r1_fatsec[39:32] == 8'd0)
                && (n2_nondata[40:32] == 9'd0)
                && (n2_nondata[31:0] < r1_tot)
                && !r1_flba[32]
                && (n2_dlba[40:32] == 9'd0)
                && !r1_end[32]
                && (n2_maxfat[45:32] == 14'd0)
                && (n2_maxfat[31:0] > 32'd2);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ok      <= n2_ok;
            r2_nondata <= n2_nondata[31:0];
            r2_dlba    <= n2_dlba[31:0];
            r2_flba    <= r1_flba[31:0];
            r2_end     <= r1_end[31:0];
            r2_tot     <= r1_tot;
            r2_root    <= r1_root;
            r2_maxfat  <= n2_maxfat[31:0];
            r2_spc     <= r1_spc;
            r2_sh      <= r1_sh;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: data sector count, volume end check
    // ------------------------------------------------------------------
    logic [31:0] n3_datasec;
    logic        n3_ok;

    logic        r3_ok;
    logic [31:0] r3_datasec;
    logic [31:0] r3_maxfat_m1;
    logic [31:0] r3_flba;
    logic [31:0] r3_dlba;
    logic [31:0] r3_root;
    logic [2:0]  r3_sh;

    // nondata is below total sectors on every beat that is still ok
    assign n3_datasec = r2_tot - r2_nondata;

    assign n3_ok = r2_ok
                && (n3_datasec >= {24'd0, r2_spc})
                && (r2_dlba < r2_end);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ok        <= n3_ok;
            r3_datasec   <= n3_datasec;
            r3_maxfat_m1 <= r2_maxfat - 32'd1;
            r3_flba      <= r2_flba;
            r3_dlba      <= r2_dlba;
            r3_root      <= r2_root;
            r3_sh        <= r2_sh;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: cluster count, highest cluster, root range
    // ------------------------------------------------------------------
    logic [31:0] s4_cc;
    logic [32:0] s4_maxdata;
    logic [31:0] n4_hi;
    logic        n4_ok;

    logic        r4_ok;
    logic [31:0] r4_hi;
    logic [31:0] r4_flba;
    logic [31:0] r4_dlba;

    // cluster size is a power of two, so the divide is a shift
    assign s4_cc      = r3_datasec >> r3_sh;
    assign s4_maxdata = {1'b0, s4_cc} + 33'd1;
    assign n4_hi      = (r3_maxfat_m1 < s4_maxdata[31:0]) ? r3_maxfat_m1 : s4_maxdata[31:0];

    assign n4_ok = r3_ok
                && (s4_cc != 32'd0)
                && !s4_maxdata[32]
                && (r3_root <= n4_hi);

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_ok   <= n4_ok;
            r4_hi   <= n4_hi;
            r4_flba <= r3_flba;
            r4_dlba <= r3_dlba;
        end
    end

    // ------------------------------------------------------------------
    // output register: invalid records give all-zero geometry
    // ------------------------------------------------------------------
    t_fbrv_out r_out;

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_out.status          <= r4_ok ? STATUS_OK : STATUS_NOT_FS;
            r_out.fat_start_lba   <= r4_ok ? r4_flba : 32'd0;
            r_out.data_start_lba  <= r4_ok ? r4_dlba : 32'd0;
            r_out.highest_cluster <= r4_ok ? r4_hi : 32'd0;
        end
    end

    assign o_out = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FBRV_ASSERT(a_invalid_zero, (o_out_valid && (o_out.status == STATUS_NOT_FS)) |-> ((o_out.fat_start_lba == 32'd0) && (o_out.data_start_lba == 32'd0) && (o_out.highest_cluster == 32'd0)), "invalid record with nonzero geometry")
    `FBRV_ASSERT(a_valid_order, (o_out_valid && (o_out.status == STATUS_OK)) |-> ((o_out.data_start_lba >= o_out.fat_start_lba) && (o_out.highest_cluster >= 32'd2)), "valid record with inconsistent geometry")
    `FBRV_ASSERT(a_cfg_write, (i_cfg_valid && o_cfg_ready) |=> (r_dev_bytes == $past(i_cfg_data)), "config write not taken")
    `FBRV_ASSERT(a_out_hold, (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)), "stalled result beat lost")
    `FBRV_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!o_out_valid && !r4_valid && !r1_valid), "pipeline not empty after reset")

endmodule
